/* hw/rtl/sse_pkg.sv */
// shared types and constants for the sample statistics engine
`timescale 1ns / 1ps

package sse_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SAMPLE_W        = 16;
	localparam int MEAN_W          = 16;
	localparam int VAR_W           = 32;
	localparam int SD_W            = 16;
	localparam int COUNT_W         = 11;
	localparam int STATUS_W        = 2;
	localparam int SQRT_ITERS      = 16;
	localparam logic [VAR_W-1:0] SQRT_BIT0 = 32'h4000_0000;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SINGLE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} in_word_t;

	typedef struct packed {
		logic [MEAN_W-1:0]   mean_value;
		logic [VAR_W-1:0]    variance_value;
		logic [SD_W-1:0]     std_deviation;
		logic [COUNT_W-1:0]  sample_count;
		logic [STATUS_W-1:0] status;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_MUL_A,
		S_MUL_B,
		S_SUB,
		S_MUL_D,
		S_DIV_V,
		S_DIV_M,
		S_SQRT,
		S_DONE
	} state_t;

endpackage

/* hw/rtl/sample_statistics_engine.sv */
// sample statistics engine: running sums, then mean, variance and std deviation
//
//  channel | signals              | direction | handshake
//  --------+----------------------+-----------+-------------------------------
//  input   | item (sample, last)  | in        | taken when start=1 and busy=0
//  result  | result (5 fields)    | out       | done high for one cycle
//
// a sample without last is summed (dropped at capacity) and busy stays low.
// a sample with last is summed, then one shared adder/subtractor runs the
// finish: n*sumsq, sum*sum, n*(n-1) by shift-and-add, two restoring divides
// and a 16-step square root. busy stays high from the last word through the
// whole finish, and done is high in its final state, S_DONE.
// reset clears the running sums and returns to idle; done cannot be held off.
`timescale 1ns / 1ps

module sample_statistics_engine #(
	parameter int MAX_SAMPLES = sse_pkg::MAX_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sse_pkg::in_word_t  item,
	output logic               done,
	output sse_pkg::out_word_t result
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = sse_pkg::SAMPLE_W + CNT_W;
	localparam int SQ_W  = 2 * sse_pkg::SAMPLE_W + CNT_W;
	localparam int NUM_W = CNT_W + SQ_W;
	localparam int D_W   = 2 * CNT_W;
	localparam int RW    = D_W + 1;
	localparam int UW    = NUM_W + 1;
	localparam int IT_W  = $clog2(NUM_W);
	localparam int VW    = sse_pkg::VAR_W;

	sse_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sq_q;
	logic             ovf_q;

	logic [NUM_W-1:0] prod_q, mcand_q, num_q;
	logic [SUM_W-1:0] mplier_q;
	logic [RW-1:0]    rem_q;
	logic [IT_W-1:0]  iter_q;
	logic [VW-1:0]    var_q, rt_q, bt_q;
	logic [sse_pkg::MEAN_W-1:0] mean_q;
	logic [sse_pkg::SD_W-1:0]   sd_q;

	logic             accept, last_it;
	logic [UW-1:0]    au_x, au_y;
	logic             au_sub;
	logic [UW:0]      au_sum;
	logic [UW-1:0]    au_res;
	logic             au_carry;
	logic [NUM_W-1:0] prod_step, num_step;
	logic [RW-1:0]    rem_sh;
	logic [VW-1:0]    rt_step, var_sat;
	logic [31:0]      sample_sq;

	assign accept    = start && !busy;
	assign last_it   = (iter_q == '0);
	assign sample_sq = 32'(item.sample) * 32'(item.sample);

	// shared adder/subtractor, carry high on subtract means no borrow
	assign rem_sh = {rem_q[RW-2:0], num_q[NUM_W-1]};

	always_comb begin
		au_x   = '0;
		au_y   = '0;
		au_sub = 1'b0;
		case (state_q)
			sse_pkg::S_MUL_A, sse_pkg::S_MUL_B, sse_pkg::S_MUL_D: begin
				au_x = UW'(prod_q);
				au_y = UW'(mcand_q);
			end
			sse_pkg::S_SUB: begin
				au_x   = UW'(num_q);
				au_y   = UW'(prod_q);
				au_sub = 1'b1;
			end
			sse_pkg::S_DIV_V: begin
				au_x   = UW'(rem_sh);
				au_y   = UW'(prod_q[D_W-1:0]);
				au_sub = 1'b1;
			end
			sse_pkg::S_DIV_M: begin
				au_x   = UW'(rem_sh);
				au_y   = UW'(cnt_q);
				au_sub = 1'b1;
			end
			sse_pkg::S_SQRT: begin
				au_x   = UW'(num_q);
				au_y   = UW'(rt_q | bt_q);
				au_sub = 1'b1;
			end
			default: begin
				au_sub = 1'b0;
			end
		endcase
	end

	assign au_sum   = {1'b0, au_x} + {1'b0, au_y ^ {UW{au_sub}}} + (UW+1)'(au_sub);
	assign au_res   = au_sum[UW-1:0];
	assign au_carry = au_sum[UW];

	assign prod_step = mplier_q[0] ? au_res[NUM_W-1:0] : prod_q;
	assign num_step  = {num_q[NUM_W-2:0], au_carry};
	assign var_sat   = (|num_step[NUM_W-1:VW]) ? '1 : num_step[VW-1:0];
	assign rt_step   = au_carry ? ((rt_q >> 1) | bt_q) : (rt_q >> 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sse_pkg::S_IDLE:  if (accept && item.last) state_d = sse_pkg::S_PREP;
			sse_pkg::S_PREP:  state_d = sse_pkg::S_MUL_A;
			sse_pkg::S_MUL_A: if (last_it) state_d = sse_pkg::S_MUL_B;
			sse_pkg::S_MUL_B: if (last_it) state_d = sse_pkg::S_SUB;
			sse_pkg::S_SUB:   state_d = sse_pkg::S_MUL_D;
			sse_pkg::S_MUL_D: if (last_it) state_d = sse_pkg::S_DIV_V;
			sse_pkg::S_DIV_V: if (last_it) state_d = sse_pkg::S_DIV_M;
			sse_pkg::S_DIV_M: if (last_it) state_d = sse_pkg::S_SQRT;
			sse_pkg::S_SQRT:  if (last_it) state_d = sse_pkg::S_DONE;
			sse_pkg::S_DONE:  state_d = sse_pkg::S_IDLE;
			default:          state_d = sse_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != sse_pkg::S_IDLE);
		done = (state_q == sse_pkg::S_DONE);
		result.sample_count   = sse_pkg::COUNT_W'(cnt_q);
		result.mean_value     = mean_q;
		result.variance_value = var_q;
		result.std_deviation  = sd_q;
		result.status         = ovf_q ? sse_pkg::ST_DROPPED : sse_pkg::ST_OK;
		if (cnt_q == '0) begin
			result.mean_value     = '0;
			result.variance_value = '0;
			result.std_deviation  = '0;
			result.status         = sse_pkg::ST_EMPTY;
		end else if (cnt_q == CNT_W'(1)) begin
			result.variance_value = '0;
			result.std_deviation  = '0;
			result.status         = sse_pkg::ST_SINGLE;
		end
	end

	// control state and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sse_pkg::S_IDLE;
			cnt_q   <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sse_pkg::S_DONE) begin
				cnt_q <= '0;
				sum_q <= '0;
				sq_q  <= '0;
				ovf_q <= 1'b0;
			end else if (accept) begin
				if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
					cnt_q <= cnt_q + CNT_W'(1);
					sum_q <= sum_q + SUM_W'(item.sample);
					sq_q  <= sq_q + SQ_W'(sample_sq);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// finishing datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sse_pkg::S_PREP: begin
				prod_q   <= '0;
				mcand_q  <= NUM_W'(sq_q);
				mplier_q <= SUM_W'(cnt_q);
				iter_q   <= IT_W'(CNT_W - 1);
			end
			sse_pkg::S_MUL_A, sse_pkg::S_MUL_B, sse_pkg::S_MUL_D: begin
				prod_q   <= prod_step;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				iter_q   <= iter_q - IT_W'(1);
				if (last_it) begin
					if (state_q == sse_pkg::S_MUL_A) begin
						num_q    <= prod_step;
						prod_q   <= '0;
						mcand_q  <= NUM_W'(sum_q);
						mplier_q <= sum_q;
						iter_q   <= IT_W'(SUM_W - 1);
					end else if (state_q == sse_pkg::S_MUL_D) begin
						rem_q  <= '0;
						iter_q <= IT_W'(NUM_W - 1);
					end
				end
			end
			sse_pkg::S_SUB: begin
				// clamp a negative numerator to zero
				num_q    <= au_carry ? au_res[NUM_W-1:0] : '0;
				prod_q   <= '0;
				mcand_q  <= NUM_W'(cnt_q - CNT_W'(1));
				mplier_q <= SUM_W'(cnt_q);
				iter_q   <= IT_W'(CNT_W - 1);
			end
			sse_pkg::S_DIV_V, sse_pkg::S_DIV_M: begin
				rem_q  <= au_carry ? au_res[RW-1:0] : rem_sh;
				num_q  <= num_step;
				iter_q <= iter_q - IT_W'(1);
				if (last_it) begin
					if (state_q == sse_pkg::S_DIV_V) begin
						var_q  <= var_sat;
						num_q  <= {sum_q, {(NUM_W-SUM_W){1'b0}}};
						rem_q  <= '0;
						iter_q <= IT_W'(SUM_W - 1);
					end else begin
						mean_q <= num_step[sse_pkg::MEAN_W-1:0];
						num_q  <= NUM_W'(var_q);
						rt_q   <= '0;
						bt_q   <= sse_pkg::SQRT_BIT0;
						iter_q <= IT_W'(sse_pkg::SQRT_ITERS - 1);
					end
				end
			end
			sse_pkg::S_SQRT: begin
				if (au_carry) num_q <= au_res[NUM_W-1:0];
				rt_q   <= rt_step;
				bt_q   <= bt_q >> 2;
				iter_q <= iter_q - IT_W'(1);
				if (last_it) sd_q <= rt_step[sse_pkg::SD_W-1:0];
			end
			default: begin
				iter_q <= iter_q;
			end
		endcase
	end

	a_done_after_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == sse_pkg::S_SQRT)
		else $error("result strobe without finished square root");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count past capacity");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == CNT_W'(MAX_SAMPLES))
		else $error("drop flag set below capacity");

	a_clear_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (cnt_q == '0) && !ovf_q && !busy)
		else $error("run state not cleared after result");

	a_last_starts_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last) |=> busy && !done)
		else $error("last word did not start the finish sequence");

endmodule
